@@ sv/lfu_cache_lru_tiebreak_macros.svh @@
// assertion macros shared by the lfu cache rtl
// expects signals named clock and reset in the including module
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

// condition must hold at every edge out of reset
`define LFUC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lfuc: invariant violated");

// consequent must hold in the same cycle as the antecedent
`define LFUC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfuc: implication violated");

// consequent must hold in the cycle after the antecedent
`define LFUC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfuc: next-cycle check violated");

`endif

@@ sv/lfuc_pkg.sv @@
// shared types and constants for the lfu cache with lru tie-break
// no dependencies
package lfuc_pkg;

   localparam int ENTRIES     = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int CAP_WIDTH   = 5;
   localparam int IDX_WIDTH   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_WIDTH  = $clog2(ENTRIES + 1);
   localparam int EFF_WIDTH   = (CAP_WIDTH > FILL_WIDTH) ? CAP_WIDTH : FILL_WIDTH;

   localparam logic [CAP_WIDTH-1:0]   CAP_RESET = CAP_WIDTH'(16);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // one stored entry of the chain
   typedef struct packed {
      logic                   valid;
      logic [KEY_WIDTH-1:0]   key;
      logic [DATA_WIDTH-1:0]  data;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   // flags a cell hands to its neighbors
   typedef struct packed {
      logic le;    // valid and count at or below the reference count
      logic give;  // this cell's entry moves into a neighbor
   } link_type;

   // broadcast control for all cells
   typedef struct packed {
      logic                   relocate;
      logic                   insert;
      logic [COUNT_WIDTH-1:0] ref_count;
      logic [KEY_WIDTH-1:0]   probe_key;
      entry_type              bus;
   } ctl_type;

endpackage

@@ sv/lfuc_cell.sv @@
// one cell of the eviction-ordered chain: holds one entry
// depends on lfuc_pkg
module lfuc_cell (
   input  logic               clock,
   input  logic               reset,
   input  lfuc_pkg::ctl_type  ctl,
   input  logic               sel,
   input  lfuc_pkg::entry_type left_ent,
   input  lfuc_pkg::link_type left_lnk,
   input  lfuc_pkg::entry_type right_ent,
   input  lfuc_pkg::link_type right_lnk,
   input  logic               beyond_in,
   output lfuc_pkg::entry_type ent,
   output lfuc_pkg::link_type lnk,
   output logic               beyond_out,
   output logic               match
);

   lfuc_pkg::entry_type ent_ff, ent_in;

   always_comb begin
      lnk.le     = ent_ff.valid && (ent_ff.count <= ctl.ref_count);
      // relocate: entries past the touched one with a small count slide left
      // insert: entries with a larger count slide right
      lnk.give   = ctl.relocate ? (lnk.le && beyond_in) : (ent_ff.valid && !lnk.le);
      beyond_out = beyond_in || sel;
      match      = ent_ff.valid && (ent_ff.key == ctl.probe_key);

      ent_in = ent_ff;
      if (ctl.relocate) begin
         if (right_lnk.give) begin
            ent_in = right_ent;
         end else if (sel || lnk.give) begin
            ent_in = ctl.bus;
         end
      end else if (ctl.insert) begin
         if (left_lnk.give) begin
            ent_in = left_ent;
         end else if (left_lnk.le && !lnk.le) begin
            ent_in = ctl.bus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.key   <= ent_in.key;
      ent_ff.data  <= ent_in.data;
      ent_ff.count <= ent_in.count;
   end

   assign ent = ent_ff;

endmodule

@@ sv/lfuc_chain.sv @@
// row of lfuc_cell kept sorted by eviction order, victim at the head
// depends on lfuc_pkg and lfuc_cell
module lfuc_chain (
   input  logic                               clock,
   input  logic                               reset,
   input  lfuc_pkg::ctl_type                  ctl,
   input  logic [lfuc_pkg::ENTRIES-1:0]       sel,
   output logic [lfuc_pkg::ENTRIES-1:0]       match,
   output logic [lfuc_pkg::ENTRIES-1:0]       valid,
   output logic [lfuc_pkg::DATA_WIDTH-1:0]    hit_data,
   output logic [lfuc_pkg::COUNT_WIDTH-1:0]   hit_count,
   output logic [lfuc_pkg::KEY_WIDTH-1:0]     head_key
);

   lfuc_pkg::entry_type ent [lfuc_pkg::ENTRIES];
   lfuc_pkg::link_type  lnk [lfuc_pkg::ENTRIES];
   logic [lfuc_pkg::ENTRIES-1:0] beyond;

   localparam lfuc_pkg::link_type EDGE_LEFT  = '{le: 1'b1, give: 1'b0};
   localparam lfuc_pkg::link_type EDGE_RIGHT = '{le: 1'b0, give: 1'b0};

   for (genvar g = 0; g < lfuc_pkg::ENTRIES; g++) begin : g_cell
      lfuc_pkg::entry_type left_ent, right_ent;
      lfuc_pkg::link_type  left_lnk, right_lnk;
      logic                beyond_in;

      if (g == 0) begin : g_head
         assign left_ent  = '0;
         assign left_lnk  = EDGE_LEFT;
         assign beyond_in = 1'b0;
      end else begin : g_body
         assign left_ent  = ent[g-1];
         assign left_lnk  = lnk[g-1];
         assign beyond_in = beyond[g-1];
      end

      if (g == lfuc_pkg::ENTRIES - 1) begin : g_tail
         assign right_ent = '0;
         assign right_lnk = EDGE_RIGHT;
      end else begin : g_inner
         assign right_ent = ent[g+1];
         assign right_lnk = lnk[g+1];
      end

      lfuc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .sel        (sel[g]),
         .left_ent   (left_ent),
         .left_lnk   (left_lnk),
         .right_ent  (right_ent),
         .right_lnk  (right_lnk),
         .beyond_in  (beyond_in),
         .ent        (ent[g]),
         .lnk        (lnk[g]),
         .beyond_out (beyond[g]),
         .match      (match[g])
      );

      assign valid[g] = ent[g].valid;
   end

   // keys are unique, so at most one cell matches
   always_comb begin
      hit_data  = '0;
      hit_count = '0;
      for (int j = 0; j < lfuc_pkg::ENTRIES; j++) begin
         hit_data  = hit_data  | (match[j] ? ent[j].data  : '0);
         hit_count = hit_count | (match[j] ? ent[j].count : '0);
      end
   end

   assign head_key = ent[0].key;

endmodule

@@ sv/lfu_cache_lru_tiebreak.sv @@
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break, built as a chain of entry cells kept sorted
// by eviction order (head cell is always the victim).
//
// req channel (valid/ready): one word per operation, req_kind 0 = get,
// 1 = put, with req_key and req_value. rsp channel (valid/ready): one word
// per operation with hit, read value, eviction flag and evicted key.
// csr_write_enable / csr_write_data set the capacity (reset 16); write it
// only while no operation is in flight.
//
// Timing: an operation has a lookup step for the key match across all
// cells and an update step for the chain update; the response is
// registered when the update is applied, and a new word is taken in the
// same cycle the previous response is loaded, and not before.
// A stalled rsp holds the output register; the block still finishes the
// next operation's lookup and then waits with req_ready low until the
// response register frees up.
// Reset empties every cell at once and sets the capacity to 16.
// depends on lfuc_pkg, lfuc_chain, lfuc_cell and the assertion macros header
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [lfuc_pkg::KEY_WIDTH-1:0] req_key,
   input  logic signed [lfuc_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic signed [lfuc_pkg::DATA_WIDTH-1:0] rsp_read_value,
   output logic                                  rsp_evicted,
   output logic signed [lfuc_pkg::KEY_WIDTH-1:0] rsp_evicted_key,
   input  logic                                  csr_write_enable,
   input  logic [lfuc_pkg::CAP_WIDTH-1:0]        csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_UPDATE} state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [lfuc_pkg::CAP_WIDTH-1:0] cap_ff;

   logic                              op_kind_ff, op_kind_in;
   logic [lfuc_pkg::KEY_WIDTH-1:0]    op_key_ff, op_key_in;
   logic [lfuc_pkg::DATA_WIDTH-1:0]   op_value_ff, op_value_in;
   logic [lfuc_pkg::ENTRIES-1:0]      match_ff, match_in;
   logic                              hit_ff, hit_in;
   logic [lfuc_pkg::DATA_WIDTH-1:0]   hit_data_ff, hit_data_in;
   logic [lfuc_pkg::COUNT_WIDTH-1:0]  hit_count_ff, hit_count_in;

   logic                              rsp_hit_ff, rsp_hit_in;
   logic [lfuc_pkg::DATA_WIDTH-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic                              rsp_evicted_ff, rsp_evicted_in;
   logic [lfuc_pkg::KEY_WIDTH-1:0]    rsp_evicted_key_ff, rsp_evicted_key_in;

   lfuc_pkg::ctl_type                 ctl;
   logic [lfuc_pkg::ENTRIES-1:0]      sel;
   logic [lfuc_pkg::ENTRIES-1:0]      match_vec, valid_vec;
   logic [lfuc_pkg::DATA_WIDTH-1:0]   chain_hit_data;
   logic [lfuc_pkg::COUNT_WIDTH-1:0]  chain_hit_count;
   logic [lfuc_pkg::KEY_WIDTH-1:0]    head_key;

   logic accept, out_free, apply;
   logic [lfuc_pkg::EFF_WIDTH-1:0] cap_ext, eff;
   logic [lfuc_pkg::IDX_WIDTH-1:0] eff_last;
   logic full, is_get, put_on, do_evict, do_insert, do_touch;
   logic [lfuc_pkg::COUNT_WIDTH-1:0] bump_count, bus_count;

   lfuc_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sel       (sel),
      .match     (match_vec),
      .valid     (valid_vec),
      .hit_data  (chain_hit_data),
      .hit_count (chain_hit_count),
      .head_key  (head_key)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      apply     = (state_ff == ST_UPDATE) && out_free;
      req_ready = (state_ff == ST_IDLE) || apply;
      accept    = req_valid && req_ready;

      // capacity above the cell count saturates
      cap_ext  = lfuc_pkg::EFF_WIDTH'(cap_ff);
      eff      = (cap_ext > lfuc_pkg::EFF_WIDTH'(lfuc_pkg::ENTRIES)) ?
                 lfuc_pkg::EFF_WIDTH'(lfuc_pkg::ENTRIES) : cap_ext;
      eff_last = lfuc_pkg::IDX_WIDTH'(eff - 1'b1);
      // valid cells are packed at the head, so fullness is one bit
      full     = valid_vec[eff_last];

      is_get    = (op_kind_ff == lfuc_pkg::KIND_GET);
      put_on    = (op_kind_ff == lfuc_pkg::KIND_PUT) && (eff != '0);
      do_evict  = put_on && !hit_ff && full;
      do_insert = put_on && !hit_ff && !full;
      do_touch  = hit_ff && (is_get || put_on);

      bump_count = (hit_count_ff == lfuc_pkg::COUNT_MAX) ?
                   lfuc_pkg::COUNT_MAX : hit_count_ff + lfuc_pkg::COUNT_ONE;
      bus_count  = hit_ff ? bump_count : lfuc_pkg::COUNT_ONE;

      ctl.relocate  = apply && (do_touch || do_evict);
      ctl.insert    = apply && do_insert;
      ctl.ref_count = bus_count;
      ctl.probe_key = op_key_ff;
      ctl.bus.valid = 1'b1;
      ctl.bus.key   = op_key_ff;
      ctl.bus.data  = is_get ? hit_data_ff : op_value_ff;
      ctl.bus.count = bus_count;
      // eviction replaces the head cell in place and lets it sink
      sel = hit_ff ? match_ff : lfuc_pkg::ENTRIES'(1);

      op_kind_in  = accept ? req_kind  : op_kind_ff;
      op_key_in   = accept ? req_key   : op_key_ff;
      op_value_in = accept ? req_value : op_value_ff;

      match_in     = match_ff;
      hit_in       = hit_ff;
      hit_data_in  = hit_data_ff;
      hit_count_in = hit_count_ff;
      if (state_ff == ST_LOOKUP) begin
         match_in     = match_vec;
         hit_in       = |match_vec;
         hit_data_in  = chain_hit_data;
         hit_count_in = chain_hit_count;
      end

      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      if (apply) begin
         rsp_hit_in         = hit_ff;
         rsp_read_value_in  = is_get ? (hit_ff ? hit_data_ff : '1) : '0;
         rsp_evicted_in     = do_evict;
         rsp_evicted_key_in = do_evict ? head_key : '0;
      end

      rsp_valid_in = apply ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = apply ? (accept ? ST_LOOKUP : ST_IDLE) : ST_UPDATE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lfuc_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
      op_kind_ff         <= op_kind_in;
      op_key_ff          <= op_key_in;
      op_value_ff        <= op_value_in;
      match_ff           <= match_in;
      hit_ff             <= hit_in;
      hit_data_ff        <= hit_data_in;
      hit_count_ff       <= hit_count_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   // keys stay unique across the chain
   `LFUC_ASSERT_ALWAYS(a_match_unique, $onehot0(match_vec))
   // valid cells stay packed toward the head
   `LFUC_ASSERT_ALWAYS(a_valid_packed, ((valid_vec >> 1) & ~valid_vec) == '0)
   // a finished update always leaves a response behind
   `LFUC_ASSERT_NEXT(a_rsp_loaded, apply, rsp_valid && (state_ff != ST_UPDATE))
   // no new word while a lookup is in progress
   `LFUC_ASSERT_IMPL(a_no_accept_lookup, state_ff == ST_LOOKUP, !req_ready)
   // the chain moves only one way per update
   `LFUC_ASSERT_ALWAYS(a_one_mode, !(ctl.relocate && ctl.insert))

endmodule
